// File: src/mep_pkg.sv
package mep_pkg;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    q_t c_im;
    q_t c_re;
  } point_t;

  localparam int QFRAC = 28;
  localparam int INTENSITY_MAX = 255;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [32:0] ESCAPE_LIMIT = 33'h0_4000_0000;

  localparam logic [2:0] REG_ORIGIN_RE = 3'd0;
  localparam logic [2:0] REG_ORIGIN_IM = 3'd1;
  localparam logic [2:0] REG_STEP_RE = 3'd2;
  localparam logic [2:0] REG_STEP_IM = 3'd3;
  localparam logic [2:0] REG_PALETTE = 3'd4;

  function automatic q_t sat32(input logic signed [47:0] v);
    q_t res;
    if (v > 48'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -48'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// File: src/mep_front.sv
module mep_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // column[11:0], row[23:12]
  input  mep_pkg::q_t       origin_re,
  input  mep_pkg::q_t       origin_im,
  input  mep_pkg::q_t       step_re,
  input  mep_pkg::q_t       step_im,
  output logic              push_valid,
  input  logic              push_ready,
  output mep_pkg::point_t   push_data
);
  import mep_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_SUM  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [11:0]        col_r, col_nxt;
  logic [11:0]        row_r, row_nxt;
  logic signed [44:0] pre_r, pre_nxt;
  logic signed [44:0] pim_r, pim_nxt;
  point_t             pt_r, pt_nxt;
  logic signed [45:0] sum_re;
  logic signed [45:0] sum_im;

  assign sum_re = 46'(origin_re) + 46'(pre_r);
  assign sum_im = 46'(origin_im) + 46'(pim_r);

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    pre_nxt   = pre_r;
    pim_nxt   = pim_r;
    pt_nxt    = pt_r;
    case (state_r)
      F_IDLE: begin
        if (in_tvalid) begin
          col_nxt   = in_tdata[11:0];
          row_nxt   = in_tdata[23:12];
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        pre_nxt   = $signed({1'b0, col_r}) * step_re;
        pim_nxt   = $signed({1'b0, row_r}) * step_im;
        state_nxt = F_SUM;
      end
      F_SUM: begin
        pt_nxt.c_re = sat32(48'(sum_re));
        pt_nxt.c_im = sat32(48'(sum_im));
        state_nxt   = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    col_r <= col_nxt;
    row_r <= row_nxt;
    pre_r <= pre_nxt;
    pim_r <= pim_nxt;
    pt_r  <= pt_nxt;
  end

  assign in_tready  = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_data  = pt_r;

endmodule

// File: src/mep_fifo.sv
module mep_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  mep_pkg::point_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mep_pkg::point_t pop_data
);
  import mep_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  point_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] fill_r, fill_nxt;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (fill_r != CNTW'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/mep_core.sv
module mep_core #(
  parameter int MAX_ITERATIONS = 100
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  mep_pkg::point_t pop_data,
  input  logic            palette,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata
);
  import mep_pkg::*;

  localparam int CW = $clog2(MAX_ITERATIONS);
  localparam int LVL_Q = INTENSITY_MAX / MAX_ITERATIONS;
  localparam int LVL_R = INTENSITY_MAX % MAX_ITERATIONS;
  localparam logic [CW:0] MAX_C = (CW + 1)'(MAX_ITERATIONS);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_UPD  = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  q_t                 cre_r, cre_nxt;
  q_t                 cim_r, cim_nxt;
  q_t                 x_r, x_nxt;
  q_t                 y_r, y_nxt;
  logic signed [63:0] pxx_r, pxx_nxt;
  logic signed [63:0] pyy_r, pyy_nxt;
  logic signed [63:0] pxy_r, pxy_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      rem_r, rem_nxt;
  logic [7:0]         lvl_r, lvl_nxt;
  logic               ov_r, ov_nxt;
  logic [31:0]        od_r, od_nxt;

  q_t                 x2;
  q_t                 y2;
  logic [32:0]        mag;
  logic signed [33:0] nx_sum;
  logic signed [37:0] ny_sum;
  logic [CW:0]        cnt_inc;
  logic [CW:0]        rem_sum;
  logic               carry;
  logic               done;
  logic [CW+6:0]      cnt_ext;
  logic [23:0]        color;

  assign x2      = sat32(48'(pxx_r[63:QFRAC]));
  assign y2      = sat32(48'(pyy_r[63:QFRAC]));
  assign mag     = {1'b0, x2[31:0]} + {1'b0, y2[31:0]};
  assign nx_sum  = 34'(x2) - 34'(y2) + 34'(cre_r);
  assign ny_sum  = 38'($signed(pxy_r[63:QFRAC-1])) + 38'(cim_r);
  assign cnt_inc = {1'b0, cnt_r} + 1'b1;
  assign done    = (mag >= ESCAPE_LIMIT) || (cnt_inc >= MAX_C);
  assign rem_sum = {1'b0, rem_r} + (CW + 1)'(LVL_R);
  assign carry   = (rem_sum >= MAX_C);
  assign cnt_ext = {7'd0, cnt_r};
  assign color   = palette ? {16'd0, lvl_r} : {8'd0, lvl_r, 8'd0};

  always_comb begin
    state_nxt = state_r;
    cre_nxt   = cre_r;
    cim_nxt   = cim_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    pxx_nxt   = pxx_r;
    pyy_nxt   = pyy_r;
    pxy_nxt   = pxy_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    lvl_nxt   = lvl_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          cre_nxt   = pop_data.c_re;
          cim_nxt   = pop_data.c_im;
          x_nxt     = pop_data.c_re;
          y_nxt     = pop_data.c_im;
          cnt_nxt   = '0;
          rem_nxt   = '0;
          lvl_nxt   = '0;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        pxx_nxt   = x_r * x_r;
        pyy_nxt   = y_r * y_r;
        pxy_nxt   = x_r * y_r;
        state_nxt = B_UPD;
      end
      B_UPD: begin
        if (done) begin
          state_nxt = B_OUT;
        end else begin
          x_nxt     = sat32(48'(nx_sum));
          y_nxt     = sat32(48'(ny_sum));
          cnt_nxt   = cnt_inc[CW-1:0];
          rem_nxt   = carry ? CW'(rem_sum - MAX_C) : rem_sum[CW-1:0];
          lvl_nxt   = lvl_r + 8'(LVL_Q) + {7'd0, carry};
          state_nxt = B_MUL;
        end
      end
      B_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          od_nxt    = {1'b0, cnt_ext[6:0], color};
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    cre_r <= cre_nxt;
    cim_r <= cim_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    pxx_r <= pxx_nxt;
    pyy_r <= pyy_nxt;
    pxy_r <= pxy_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    lvl_r <= lvl_nxt;
    od_r  <= od_nxt;
  end

  assign pop_ready  = (state_r == B_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

endmodule

// File: src/mandelbrot_escape_pixel.sv
// Steps: the front captures, multiplies, sums and pushes the pixel's point; the
// point passes the queue; the core squares and updates per iteration, then loads
// the output register. The core takes a new point only after the last result is
// loaded; pixel mapping overlaps the iterations.
// Reset (rst_n low, synchronous): queue and handshakes cleared, registers
// return to their reset values.
module mandelbrot_escape_pixel #(
  parameter int MAX_ITERATIONS = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // column[11:0], row[23:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // color[23:0], escape_count[30:24], zero[31]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mep_pkg::*;

  q_t     origin_re_r;
  q_t     origin_im_r;
  q_t     step_re_r;
  q_t     step_im_r;
  logic   palette_r;
  logic   wr_en;
  logic [2:0] reg_idx;

  logic   push_valid;
  logic   push_ready;
  point_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  point_t pop_data;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_re_r <= -32'sd536870912;
      origin_im_r <= 32'sd268435456;
      step_re_r   <= 32'sd671088;
      step_im_r   <= -32'sd671088;
      palette_r   <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ORIGIN_RE: origin_re_r <= cfg_pwdata;
        REG_ORIGIN_IM: origin_im_r <= cfg_pwdata;
        REG_STEP_RE:   step_re_r   <= cfg_pwdata;
        REG_STEP_IM:   step_im_r   <= cfg_pwdata;
        REG_PALETTE:   palette_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORIGIN_RE: cfg_prdata = origin_re_r;
      REG_ORIGIN_IM: cfg_prdata = origin_im_r;
      REG_STEP_RE:   cfg_prdata = step_re_r;
      REG_STEP_IM:   cfg_prdata = step_im_r;
      REG_PALETTE:   cfg_prdata = {31'd0, palette_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  mep_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .origin_re  (origin_re_r),
    .origin_im  (origin_im_r),
    .step_re    (step_re_r),
    .step_im    (step_im_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mep_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mep_core #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .palette    (palette_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: src/mep_checker.sv
module mep_checker #(
  parameter int MAX_ITERATIONS = 100
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("cfg_pready dropped");

  a_red_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31] == 1'b0 && out_tdata[23:16] == 8'd0)
    else $error("red channel or pad bit set");

  a_one_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:8] == 8'd0 || out_tdata[7:0] == 8'd0)
    else $error("both green and blue set");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (MAX_ITERATIONS >= 128) || out_tdata[30:24] < 7'(MAX_ITERATIONS))
    else $error("escape count above cap");

endmodule

bind mandelbrot_escape_pixel mep_checker #(
  .MAX_ITERATIONS (MAX_ITERATIONS)
) u_mep_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
